// ===== hdl/ilba_pkg.sv =====
package ilba_pkg;

    // default arena size in 8-byte words
    localparam int DEFAULT_ARENA_WORDS = 512;

    // payload widths
    localparam int REQ_W    = 13;
    localparam int OFF_W    = 13;
    localparam int DOFS_W   = 12;
    localparam int STATUS_W = 3;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_START    = 3'd6;

    // one finished result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DOFS_W-1:0]   data_offset;
    } result_t;

endpackage

// ===== hdl/ilba_ram.sv =====
module ilba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ilba_ctrl.sv =====
module ilba_ctrl #(
    parameter int ARENA_WORDS = ilba_pkg::DEFAULT_ARENA_WORDS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       mode,
    input  logic [ilba_pkg::REQ_W-1:0] request_bytes,
    input  logic [ilba_pkg::OFF_W-1:0] block_offset,
    output logic                       done_valid,
    output ilba_pkg::result_t          done_result,
    input  logic                       done_ready
);

    import ilba_pkg::*;

    // address width, word count width, header entry width
    localparam int NW = $clog2(ARENA_WORDS);
    localparam int CW = $clog2(ARENA_WORDS + 1);
    localparam int HW = NW + 1;
    localparam int XW = (CW > 11) ? CW : 11;
    localparam int OW = $clog2(ARENA_WORDS * 8 + 1);
    localparam int BW = (OW > OFF_W) ? OW : OFF_W;
    localparam int TW = (NW > 10) ? NW : 10;

    // controller states
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_AWALK  = 4'd2;
    localparam logic [3:0] S_ASPLIT = 4'd3;
    localparam logic [3:0] S_FWALK  = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MHEAD  = 4'd6;
    localparam logic [3:0] S_MCHECK = 4'd7;
    localparam logic [3:0] S_MNEXT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] cur_w_reg, cur_w_next;
    logic [NW-1:0] cur_size_reg, cur_size_next;
    logic          cur_occ_reg, cur_occ_next;
    logic [NW-1:0] need_reg, need_next;
    logic [NW-1:0] tw_reg, tw_next;
    result_t       result_reg, result_next;

    logic          mem_en;
    logic          mem_we;
    logic [NW-1:0] mem_addr;
    logic [HW-1:0] mem_wdata;
    logic [HW-1:0] mem_rdata;
    logic          rd_occ;
    logic [NW-1:0] rd_size;

    logic [13:0]   rq_sum;
    logic [XW-1:0] need_x;
    logic          off_big;
    logic [TW-1:0] tw_x;
    logic [CW-1:0] n_rd;
    logic [CW-1:0] n_cur;
    logic [CW-1:0] n_after;
    logic [CW-1:0] merged;
    logic [DOFS_W-1:0] cur_dofs;

    // header memory: {occupied, size in words}
    ilba_ram #(
        .WIDTH (HW),
        .DEPTH (ARENA_WORDS)
    ) u_hdr_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign rd_occ  = mem_rdata[NW];
    assign rd_size = mem_rdata[NW-1:0];

    // request decode
    assign rq_sum  = 14'(request_bytes) + 14'd7;
    assign need_x  = XW'(rq_sum[13:3]);
    assign off_big = BW'(block_offset) >= BW'(ARENA_WORDS * 8);
    assign tw_x    = TW'(block_offset[OFF_W-1:3]) - TW'(1);

    // next block starts
    assign n_rd     = CW'(cur_w_reg) + CW'(rd_size) + CW'(1);
    assign n_cur    = CW'(cur_w_reg) + CW'(cur_size_reg) + CW'(1);
    assign n_after  = n_cur + CW'(rd_size) + CW'(1);
    assign merged   = CW'(cur_size_reg) + CW'(rd_size) + CW'(1);
    assign cur_dofs = DOFS_W'({cur_w_reg, 3'b000}) + DOFS_W'(8);

    assign in_ready    = (state_reg == S_IDLE);
    assign done_valid  = (state_reg == S_DONE);
    assign done_result = result_reg;

    // walk sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_w_next    = cur_w_reg;
        cur_size_next = cur_size_reg;
        cur_occ_next  = cur_occ_reg;
        need_next     = need_reg;
        tw_next       = tw_reg;
        result_next   = result_reg;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = '0;
        mem_wdata     = '0;
        unique case (state_reg)
            S_INIT:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_wdata  = {1'b0, NW'(ARENA_WORDS - 1)};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    result_next.status      = ST_OK;
                    result_next.data_offset = '0;
                    cur_w_next              = '0;
                    if (mode == MODE_ALLOC)
                    begin
                        if (request_bytes == '0)
                        begin
                            result_next.status = ST_ZERO_SIZE;
                            state_next         = S_DONE;
                        end
                        else if (need_x > XW'(ARENA_WORDS - 1))
                        begin
                            result_next.status = ST_TOO_LARGE;
                            state_next         = S_DONE;
                        end
                        else
                        begin
                            need_next  = NW'(need_x);
                            mem_en     = 1'b1;
                            state_next = S_AWALK;
                        end
                    end
                    else if (off_big)
                    begin
                        result_next.status = ST_OUTSIDE;
                        state_next         = S_DONE;
                    end
                    else if (block_offset[2:0] != 3'b000 || block_offset[OFF_W-1:3] == '0)
                    begin
                        result_next.status = ST_NOT_START;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        tw_next    = NW'(tw_x);
                        mem_en     = 1'b1;
                        state_next = S_FWALK;
                    end
                end
            end
            S_AWALK:
            begin
                if (!rd_occ && rd_size >= need_reg)
                begin
                    cur_size_next           = rd_size;
                    mem_en                  = 1'b1;
                    mem_we                  = 1'b1;
                    mem_addr                = cur_w_reg;
                    result_next.data_offset = cur_dofs;
                    if (CW'(rd_size) >= CW'(need_reg) + CW'(2))
                    begin
                        mem_wdata  = {1'b1, need_reg};
                        state_next = S_ASPLIT;
                    end
                    else
                    begin
                        mem_wdata  = {1'b1, rd_size};
                        state_next = S_DONE;
                    end
                end
                else if (n_rd >= CW'(ARENA_WORDS))
                begin
                    result_next.status = ST_NO_SPACE;
                    state_next         = S_DONE;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = NW'(n_rd);
                    cur_w_next = NW'(n_rd);
                end
            end
            S_ASPLIT:
            begin
                // free remainder behind the allocated block
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = NW'(CW'(cur_w_reg) + CW'(need_reg) + CW'(1));
                mem_wdata  = {1'b0, cur_size_reg - need_reg - NW'(1)};
                state_next = S_DONE;
            end
            S_FWALK:
            begin
                if (cur_w_reg == tw_reg)
                begin
                    if (rd_occ)
                    begin
                        mem_en    = 1'b1;
                        mem_we    = 1'b1;
                        mem_addr  = cur_w_reg;
                        mem_wdata = {1'b0, rd_size};
                    end
                    else
                    begin
                        result_next.status = ST_ALREADY_FREE;
                    end
                    state_next = S_MSTART;
                end
                else if (cur_w_reg > tw_reg || n_rd >= CW'(ARENA_WORDS))
                begin
                    result_next.status = ST_NOT_START;
                    state_next         = S_DONE;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = NW'(n_rd);
                    cur_w_next = NW'(n_rd);
                end
            end
            S_MSTART:
            begin
                mem_en     = 1'b1;
                cur_w_next = '0;
                state_next = S_MHEAD;
            end
            S_MHEAD:
            begin
                cur_size_next = rd_size;
                cur_occ_next  = rd_occ;
                if (n_rd >= CW'(ARENA_WORDS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = NW'(n_rd);
                    state_next = S_MCHECK;
                end
            end
            S_MCHECK:
            begin
                if (!cur_occ_reg && !rd_occ)
                begin
                    // absorb the next block, then look past it
                    mem_en        = 1'b1;
                    mem_we        = 1'b1;
                    mem_addr      = cur_w_reg;
                    mem_wdata     = {1'b0, NW'(merged)};
                    cur_size_next = NW'(merged);
                    state_next    = S_MNEXT;
                end
                else
                begin
                    cur_w_next    = NW'(n_cur);
                    cur_size_next = rd_size;
                    cur_occ_next  = rd_occ;
                    if (n_after >= CW'(ARENA_WORDS))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_en   = 1'b1;
                        mem_addr = NW'(n_after);
                    end
                end
            end
            S_MNEXT:
            begin
                if (n_cur >= CW'(ARENA_WORDS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = NW'(n_cur);
                    state_next = S_MCHECK;
                end
            end
            S_DONE:
            begin
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        cur_w_reg    <= cur_w_next;
        cur_size_reg <= cur_size_next;
        cur_occ_reg  <= cur_occ_next;
        need_reg     <= need_next;
        tw_reg       <= tw_next;
        result_reg   <= result_next;
    end

endmodule

// ===== hdl/implicit_list_block_allocator_top.sv =====
// zero size, too large, outside and misaligned requests are answered from the idle state without a header read;
// allocate: a first-fit walk reads one header per block, plus a write of the remainder header on a split
// a free walks to its block, then a merge pass over the arena folds adjacent free blocks;
// the single-port header RAM sets the pace
// one item at a time; a finished result waits in the output register while the next is taken
// reset: the init state entered on reset writes the single free block into entry 0
module implicit_list_block_allocator_top #(
    parameter int ARENA_WORDS = ilba_pkg::DEFAULT_ARENA_WORDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [ilba_pkg::REQ_W-1:0]    request_bytes,
    input  logic [ilba_pkg::OFF_W-1:0]    block_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ilba_pkg::STATUS_W-1:0] status,
    output logic [ilba_pkg::DOFS_W-1:0]   data_offset
);

    import ilba_pkg::*;

    logic    done_valid;
    logic    done_ready;
    result_t done_result;
    logic    out_valid_reg;
    result_t out_reg;

    ilba_ctrl #(
        .ARENA_WORDS (ARENA_WORDS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .request_bytes (request_bytes),
        .block_offset  (block_offset),
        .done_valid    (done_valid),
        .done_result   (done_result),
        .done_ready    (done_ready)
    );

    // output register takes a new beat when empty or drained
    assign done_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ready)
        begin
            out_valid_reg <= done_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            out_reg <= done_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign data_offset = out_reg.data_offset;

    // checks
    a_no_accept_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && done_valid))
        else $error("input taken while a result is pending in the controller");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("controller still ready after taking a beat");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (done_valid && done_ready) |=> (out_valid && !done_valid))
        else $error("finished result not moved into the output register");

    a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (data_offset == '0))
        else $error("failed request carries a nonzero data offset");

endmodule

// ===== tb/sv/tb_implicit_list_block_allocator_top.sv =====
module tb_implicit_list_block_allocator_top;

    import ilba_pkg::*;

    localparam int ARENA_WORDS = DEFAULT_ARENA_WORDS;
    localparam int HDR_BYTES   = 8;
    localparam int ARENA_BYTES = ARENA_WORDS * 8;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 3 * ARENA_WORDS + 16;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                mode;
    logic [REQ_W-1:0]    request_bytes;
    logic [OFF_W-1:0]    block_offset;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [DOFS_W-1:0]   data_offset;

    // predicted arena: data bytes and occupied mark per header word
    logic [12:0] blk_bytes [ARENA_WORDS];
    logic        blk_busy  [ARENA_WORDS];

    result_t pending_results[$];
    int      live_blocks[$];
    int      freed_blocks[$];
    int      mismatch_count;
    bit      quiet;

    implicit_list_block_allocator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .request_bytes (request_bytes),
        .block_offset  (block_offset),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_offset   (data_offset)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // arena after reset: one free block spanning everything
    function automatic void clear_arena();
        for (int k = 0; k < ARENA_WORDS; k++)
        begin
            blk_bytes[k] = '0;
            blk_busy[k]  = 1'b0;
        end
        blk_bytes[0] = 13'(ARENA_BYTES - HDR_BYTES);
    endfunction

    function automatic int next_block(int w);
        return w + 1 + (int'(blk_bytes[w]) >> 3);
    endfunction

    // fold every run of adjacent free blocks into its first block
    function automatic void coalesce_free();
        int w;
        int n;
        w = 0;
        while (w < ARENA_WORDS)
        begin
            n = next_block(w);
            if (n < ARENA_WORDS && !blk_busy[w] && !blk_busy[n])
            begin
                blk_bytes[w] = 13'(int'(blk_bytes[w]) + HDR_BYTES + int'(blk_bytes[n]));
                blk_bytes[n] = '0;
            end
            else
                w = n;
        end
    endfunction

    // first-fit allocate or free, updating the predicted arena
    function automatic result_t predict_result(input logic m, input logic [REQ_W-1:0] rb,
                                               input logic [OFF_W-1:0] bo);
        result_t r;
        int      need;
        int      off;
        int      w;
        int      old_bytes;
        int      rest_word;
        bit      found;
        r.status      = ST_OK;
        r.data_offset = '0;
        found         = 1'b0;
        w             = 0;
        if (m == MODE_ALLOC)
        begin
            need = (int'(rb) + 7) & ~7;
            if (rb == 0)
                r.status = ST_ZERO_SIZE;
            else if (need > ARENA_BYTES - HDR_BYTES)
                r.status = ST_TOO_LARGE;
            else
            begin
                r.status = ST_NO_SPACE;
                while (w < ARENA_WORDS && !found)
                begin
                    if (!blk_busy[w] && int'(blk_bytes[w]) >= need)
                    begin
                        old_bytes = int'(blk_bytes[w]);
                        // split only when the remainder can hold some data
                        if (old_bytes >= need + 2 * HDR_BYTES)
                        begin
                            rest_word            = w + 1 + need / 8;
                            blk_bytes[w]         = 13'(need);
                            blk_bytes[rest_word] = 13'(old_bytes - need - HDR_BYTES);
                            blk_busy[rest_word]  = 1'b0;
                        end
                        blk_busy[w]   = 1'b1;
                        r.status      = ST_OK;
                        r.data_offset = DOFS_W'(w * 8 + HDR_BYTES);
                        found         = 1'b1;
                    end
                    else
                        w = next_block(w);
                end
            end
        end
        else
        begin
            off = int'(bo);
            if (off >= ARENA_BYTES)
                r.status = ST_OUTSIDE;
            else
            begin
                r.status = ST_NOT_START;
                while (w < ARENA_WORDS && !found)
                begin
                    if (w * 8 + HDR_BYTES == off)
                    begin
                        if (!blk_busy[w])
                            r.status = ST_ALREADY_FREE;
                        else
                        begin
                            blk_busy[w] = 1'b0;
                            r.status    = ST_OK;
                        end
                        coalesce_free();
                        found = 1'b1;
                    end
                    else
                        w = next_block(w);
                end
            end
        end
        return r;
    endfunction

    // send one request beat; valid stays high on return
    task automatic send_item(input logic m, input logic [REQ_W-1:0] rb,
                             input logic [OFF_W-1:0] bo);
        result_t want;
        int      gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        request_bytes <= rb;
        block_offset  <= bo;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        want = predict_result(m, rb, bo);
        pending_results.push_back(want);
        // keep track of live and released blocks for later requests
        if (want.status == ST_OK)
        begin
            if (m == MODE_ALLOC)
                live_blocks.push_back(int'(want.data_offset));
            else
            begin
                for (int k = live_blocks.size() - 1; k >= 0; k--)
                    if (live_blocks[k] == int'(bo))
                        live_blocks.delete(k);
                freed_blocks.push_back(int'(bo));
                if (freed_blocks.size() > 16)
                    void'(freed_blocks.pop_front());
            end
        end
    endtask

    // hold off the sender until every result beat is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // one random beat: mostly well-formed traffic, some malformed frees and sizes
    task automatic send_random_item();
        int               pick;
        int               pos;
        int               bytes;
        logic [REQ_W-1:0] noise;
        noise = REQ_W'($urandom_range(0, 8191));
        pick  = $urandom_range(0, 99);
        if (pick < 30 && live_blocks.size() > 0)
        begin
            pos = $urandom_range(0, live_blocks.size() - 1);
            send_item(MODE_FREE, noise, OFF_W'(live_blocks[pos]));
        end
        else if (pick < 36 && freed_blocks.size() > 0)
        begin
            pos = $urandom_range(0, freed_blocks.size() - 1);
            send_item(MODE_FREE, noise, OFF_W'(freed_blocks[pos]));
        end
        else if (pick < 42)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(MODE_FREE, noise, OFF_W'($urandom_range(0, ARENA_WORDS - 1) * 8));
            else
                send_item(MODE_FREE, noise, OFF_W'($urandom_range(0, ARENA_BYTES - 1)));
        end
        else if (pick < 45)
            send_item(MODE_FREE, noise, OFF_W'($urandom_range(ARENA_BYTES, 8191)));
        else if (pick < 47)
            send_item(MODE_ALLOC, '0, OFF_W'(noise));
        else if (pick < 50)
            send_item(MODE_ALLOC, REQ_W'($urandom_range(ARENA_BYTES - HDR_BYTES + 1, 8191)),
                      OFF_W'(noise));
        else
        begin
            pos = $urandom_range(0, 19);
            if (pos < 13)
                bytes = $urandom_range(1, 128);
            else if (pos < 18)
                bytes = $urandom_range(129, 1024);
            else
                bytes = $urandom_range(1025, ARENA_BYTES - HDR_BYTES);
            send_item(MODE_ALLOC, REQ_W'(bytes), OFF_W'(noise));
        end
    endtask

    // zero size, too large, whole-arena grab, no space
    task automatic test_size_limits();
        send_item(MODE_ALLOC, '0, 13'd8191);
        send_item(MODE_ALLOC, 13'd8191, '0);
        send_item(MODE_ALLOC, 13'(ARENA_BYTES - HDR_BYTES + 1), '0);
        send_item(MODE_ALLOC, 13'(ARENA_BYTES - HDR_BYTES), '0);
        send_item(MODE_ALLOC, 13'd1, '0);
        send_item(MODE_FREE, 13'd8191, 13'(HDR_BYTES));
    endtask

    // tight fit keeps the block size, split leaves a minimal remainder
    task automatic test_tight_fit();
        send_item(MODE_ALLOC, 13'(ARENA_BYTES - 2 * HDR_BYTES), '0);
        send_item(MODE_FREE, '0, 13'(HDR_BYTES));
        send_item(MODE_ALLOC, 13'(ARENA_BYTES - 3 * HDR_BYTES), '0);
        send_item(MODE_ALLOC, 13'd8, '0);
        send_item(MODE_ALLOC, 13'd1, '0);
        send_item(MODE_FREE, '0, 13'(ARENA_BYTES - HDR_BYTES));
        send_item(MODE_FREE, '0, 13'(HDR_BYTES));
    endtask

    // outside, not a block start, double free and merging
    task automatic test_free_checks();
        send_item(MODE_ALLOC, 13'd16, '0);
        send_item(MODE_ALLOC, 13'd24, '0);
        send_item(MODE_ALLOC, 13'd100, '0);
        send_item(MODE_FREE, '0, 13'(ARENA_BYTES));
        send_item(MODE_FREE, '0, 13'd8191);
        send_item(MODE_FREE, '0, '0);
        send_item(MODE_FREE, '0, 13'(ARENA_BYTES - 1));
        send_item(MODE_FREE, '0, 13'd12);
        send_item(MODE_FREE, '0, 13'd32);
        send_item(MODE_FREE, '0, 13'd32);
        send_item(MODE_FREE, '0, 13'd8);
        send_item(MODE_FREE, '0, 13'd64);
    endtask

    // random traffic with idling, draining now and then
    task automatic test_random_traffic(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_random_item();
            if (k % 120 == 119)
                drain_results();
        end
    endtask

    // back-to-back tail with no idling on either side
    task automatic test_quiet_tail(input int count);
        quiet = 1'b1;
        for (int k = 0; k < count; k++)
            send_random_item();
    endtask

    // receiver stalls in random bursts
    initial
    begin : ready_pattern
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                hold = 0;
            else if (hold == 0 && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 8);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest prediction
    always @(negedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: status %0d data_offset %0d",
                       status, data_offset);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
                if (data_offset !== want.data_offset)
                begin
                    $error("data_offset mismatch: expected %0d, actual %0d",
                           want.data_offset, data_offset);
                    mismatch_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("implicit_list_block_allocator_top test failed");
        $finish;
    end

    initial
    begin
        mismatch_count = 0;
        quiet          = 1'b0;
        clear_arena();
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        mode          <= MODE_ALLOC;
        request_bytes <= '0;
        block_offset  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_size_limits();
        test_tight_fit();
        test_free_checks();
        test_random_traffic(455);
        test_quiet_tail(60);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("implicit_list_block_allocator_top test passed");
        else
            $display("implicit_list_block_allocator_top test failed");
        $finish;
    end

endmodule
